// File: design/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed decimal ASCII converter: character
// codes, the divide-by-ten reciprocal, and the controller/datapath buses.
// ----------------------------------------------------------------------------
`default_nettype none

package sitda_pkg;

  // Default character limit of one converted number
  localparam int MAX_CHARS_DEF = 64;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Decimal digit storage: a 32-bit magnitude has at most ten digits
  localparam int MAX_DIGITS = 10;
  localparam int DIG_W      = 4;

  // Field widths of the input transaction
  localparam int VALUE_W = 32;
  localparam int WIDTH_W = 7;
  localparam int IN_W    = 40;
  localparam int CHAR_W  = 8;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture a new input transaction
    logic step;   // peel off one decimal digit
    logic size;   // fix the character count and the padding
    logic emit;   // load the next character into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic q_zero;   // quotient of the current step is zero: last digit
    logic at_last;  // the character being emitted is the final one
  } sts_t;

endpackage

`default_nettype wire

// File: design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer to right-justified decimal ASCII text,
// space padded to a minimum width, one character per output transaction.
//
//   Channel   Dir  Payload                               Marker
//   s_axis    in   tdata[31:0] value, [38:32] min_width  -
//   m_axis    out  tdata[7:0] char_code                  tlast: final character
//
// One number passes an accept state, the divide-by-ten loop at one decimal digit
// (1 to 10) per cycle, a sizing state, then one character per cycle unless stalled
// (max of text length and min_width, up to MAX_CHARS) at the output register.
// Input is taken only between numbers; a stalled output holds the emitter.
// The last character of one number may still wait while the next is taken.
// Reset (synchronous, active high) clears only the controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int MAX_CHARS = sitda_pkg::MAX_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [sitda_pkg::IN_W-1:0]    s_tdata,  // [31:0] value, [38:32] min_width
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [sitda_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] char_code
  output      logic                          m_tlast   // last character
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  // Sequencer
  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Conversion datapath
  sitda_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk     (clk),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .sts     (sts),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire

// File: design/sitda_dp.sv
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude and sign capture, one digit per cycle through a
// reciprocal multiply, digit store, and the character output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_dp #(
  parameter int MAX_CHARS = sitda_pkg::MAX_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic [sitda_pkg::IN_W-1:0]    s_tdata,  // [31:0] value, [38:32] min_width
  input  wire sitda_pkg::cmd_t               cmd,
  output      sitda_pkg::sts_t               sts,
  output      logic [sitda_pkg::CHAR_W-1:0]  m_tdata,  // [7:0] char_code
  output      logic                          m_tlast   // last character of the number
);

  localparam int CntW = $clog2(MAX_CHARS + 1);
  localparam int CmpW = (CntW > sitda_pkg::WIDTH_W) ? CntW : sitda_pkg::WIDTH_W;

  // Working registers
  logic [31:0]                   mag;
  logic                          neg;
  logic [CntW-1:0]               width_sat;
  logic [sitda_pkg::DIG_W-1:0]   nd;
  logic [sitda_pkg::DIG_W-1:0]   digit [sitda_pkg::MAX_DIGITS];
  logic [CntW-1:0]               total;
  logic [CntW-1:0]               pad;
  logic [CntW-1:0]               k;

  // Input decode
  logic [31:0]     raw;
  logic [CmpW-1:0] w_ext;
  logic [CntW-1:0] w_sat_next;

  assign raw   = s_tdata[sitda_pkg::VALUE_W-1:0];
  assign w_ext = CmpW'(s_tdata[sitda_pkg::VALUE_W +: sitda_pkg::WIDTH_W]);

  always_comb begin
    if (w_ext > CmpW'(MAX_CHARS)) begin
      w_sat_next = CntW'(MAX_CHARS);
    end else begin
      w_sat_next = CntW'(w_ext);
    end
  end

  // Divide by ten: reciprocal multiply, then remainder by shift-and-add
  logic [63:0] prod;
  logic [28:0] quot;
  logic [31:0] q10;
  logic [31:0] rem_full;

  assign prod     = {32'b0, mag} * {32'b0, sitda_pkg::RECIP_10};
  assign quot     = prod[sitda_pkg::RECIP_SHIFT +: 29];
  assign q10      = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem_full = mag - q10;

  // Text length and character selection
  logic [CntW-1:0]             len;
  logic [CntW-1:0]             didx_full;
  logic [sitda_pkg::DIG_W-1:0] didx;
  logic [sitda_pkg::DIG_W-1:0] dsel;
  logic [sitda_pkg::CHAR_W-1:0] ch;
  logic                        at_last;

  assign len       = CntW'(nd) + CntW'(neg);
  assign didx_full = total - k - CntW'(1);
  assign didx      = didx_full[sitda_pkg::DIG_W-1:0];
  assign at_last   = (k == total - CntW'(1));

  always_comb begin
    if (didx < sitda_pkg::DIG_W'(sitda_pkg::MAX_DIGITS)) begin
      dsel = digit[didx];
    end else begin
      dsel = '0;
    end
    if (k < pad) begin
      ch = sitda_pkg::CH_SPACE;
    end else if (neg && (k == pad)) begin
      ch = sitda_pkg::CH_MINUS;
    end else begin
      ch = sitda_pkg::CH_ZERO + sitda_pkg::CHAR_W'(dsel);
    end
  end

  assign sts.q_zero  = (quot == '0);
  assign sts.at_last = at_last;

  // Capture, digit loop, sizing and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg       <= raw[31];
      mag       <= raw[31] ? (~raw + 32'd1) : raw;
      width_sat <= w_sat_next;
      nd        <= '0;
    end
    if (cmd.step) begin
      digit[nd] <= rem_full[sitda_pkg::DIG_W-1:0];
      nd        <= nd + sitda_pkg::DIG_W'(1);
      mag       <= {3'b000, quot};
    end
    if (cmd.size) begin
      if (width_sat > len) begin
        total <= width_sat;
        pad   <= width_sat - len;
      end else begin
        total <= len;
        pad   <= '0;
      end
      k <= '0;
    end
    if (cmd.emit) begin
      m_tdata <= ch;
      m_tlast <= at_last;
      k       <= k + CntW'(1);
    end
  end

endmodule

`default_nettype wire

// File: design/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl
// Controller: sequences capture, the digit loop, sizing and character
// emission, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sitda_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output      logic            s_tready,
  output      logic            m_tvalid,
  input  wire logic            m_tready,
  output      sitda_pkg::cmd_t cmd,
  input  wire sitda_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIZE,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // Decode commands and next state
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        cmd.step = 1'b1;
        if (sts.q_zero) begin
          state_next = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || m_tready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          if (sts.at_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // A character is never loaded over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || m_tready))
    else $error("output register overwritten while stalled");

  // An accepted transaction always starts the digit loop
  a_accept_converts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_CONVERT))
    else $error("accepted transaction did not start conversion");

  // Leaving emission always follows the final character
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EMIT) && (state_next == ST_IDLE)) |-> (cmd.emit && sts.at_last))
    else $error("emission ended before the last character");
`endif

endmodule

`default_nettype wire

// File: tb/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii
// Self-checking bench for the signed decimal ASCII converter. Each accepted
// number is expanded into its expected right-justified text. Every output
// transaction is compared in order against that text: padding spaces, minus
// sign, digits and the final-character marker. Directed corner values come
// first, then random numbers in three back-pressure phases.
// ----------------------------------------------------------------------------

module tb_signed_int_to_decimal_ascii;

  localparam int CHAR_LIMIT = sitda_pkg::MAX_CHARS_DEF;

  typedef struct packed {
    logic [sitda_pkg::CHAR_W-1:0] code;
    logic                         last;
  } text_char_t;

  // Expected text of every accepted number, oldest character first
  class decimal_text_predictor;
    text_char_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    // Expand one accepted number into its padded decimal text
    function void note_number(logic [sitda_pkg::VALUE_W-1:0] value,
                              logic [sitda_pkg::WIDTH_W-1:0] min_width);
      logic [sitda_pkg::VALUE_W-1:0] mag;
      logic [sitda_pkg::CHAR_W-1:0]  digit_codes[$];
      logic                          neg;
      int                            text_len;
      int                            field;
      int                            total;
      text_char_t                    ch;
      neg = value[sitda_pkg::VALUE_W-1];
      mag = neg ? (~value + 1'b1) : value;
      do begin
        digit_codes.push_front(sitda_pkg::CH_ZERO + sitda_pkg::CHAR_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      text_len = digit_codes.size() + (neg ? 1 : 0);
      field = (int'(min_width) > CHAR_LIMIT) ? CHAR_LIMIT : int'(min_width);
      total = (field > text_len) ? field : text_len;
      ch.last = 1'b0;
      for (int i = text_len; i < total; i++) begin
        ch.code = sitda_pkg::CH_SPACE;
        expected_chars.push_back(ch);
      end
      if (neg) begin
        ch.code = sitda_pkg::CH_MINUS;
        expected_chars.push_back(ch);
      end
      foreach (digit_codes[i]) begin
        ch.code = digit_codes[i];
        expected_chars.push_back(ch);
      end
      expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    // Compare one output transaction with the oldest expected character
    function void check_char(logic [sitda_pkg::CHAR_W-1:0] code, logic last);
      text_char_t exp_ch;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, got code %h last %b",
                 $time, code, last);
        errors++;
        return;
      end
      exp_ch = expected_chars.pop_front();
      if (exp_ch.code !== code || exp_ch.last !== last) begin
        $display("%0t: character mismatch: expected code %h last %b, got code %h last %b",
                 $time, exp_ch.code, exp_ch.last, code, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [sitda_pkg::IN_W-1:0]   s_tdata = '0;   // [31:0] value, [38:32] min_width
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [sitda_pkg::CHAR_W-1:0] m_tdata;        // [7:0] char_code
  logic                         m_tlast;

  int send_gap_pct = 17;
  int recv_stall_pct = 62;

  decimal_text_predictor text_model;

  signed_int_to_decimal_ascii uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the output at random and check every accepted character
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      text_model.check_char(m_tdata, m_tlast);
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one number, idling first at the current gap rate
  task automatic send_number(logic [sitda_pkg::VALUE_W-1:0] value,
                             logic [sitda_pkg::WIDTH_W-1:0] min_width);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= sitda_pkg::IN_W'({$urandom(), $urandom()});
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, min_width, value};
    do @(posedge clk); while (!s_tready);
    text_model.note_number(value, min_width);
  endtask

  // Mix full-range values with short, boundary and extreme ones
  function automatic logic [sitda_pkg::VALUE_W-1:0] pick_value();
    logic [sitda_pkg::VALUE_W-1:0] v;
    logic [sitda_pkg::VALUE_W-1:0] pow10;
    int                            k;
    pow10 = 1;
    case ($urandom_range(4))
      0: v = $urandom_range(999);
      1: begin
        k = $urandom_range(9);
        for (int i = 0; i < k; i++) pow10 = pow10 * 10;
        v = pow10 - $urandom_range(1);
      end
      2: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0001;
          3: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom();
    endcase
    if ($urandom_range(1) == 1 && v != 32'h8000_0000 && v != 32'h7FFF_FFFF)
      v = ~v + 1'b1;
    return v;
  endfunction

  // Mostly narrow fields, some up to the limit, a few saturating codes
  function automatic logic [sitda_pkg::WIDTH_W-1:0] pick_width();
    case ($urandom_range(9))
      0:       return '0;
      6, 7:    return sitda_pkg::WIDTH_W'($urandom_range(16, CHAR_LIMIT));
      8:       return sitda_pkg::WIDTH_W'($urandom_range(CHAR_LIMIT + 1, 127));
      default: return sitda_pkg::WIDTH_W'($urandom_range(15));
    endcase
  endfunction

  // Main stimulus
  initial begin
    text_model = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners: zero, extremes, digit-count boundaries, padding cases
    send_number(32'd0, 7'd0);
    send_number(32'd0, 7'd64);
    send_number(32'd0, 7'd1);
    send_number(32'h8000_0000, 7'd0);
    send_number(32'h8000_0000, 7'd11);
    send_number(32'h8000_0000, 7'd64);
    send_number(32'h7FFF_FFFF, 7'd0);
    send_number(32'h7FFF_FFFF, 7'd12);
    send_number(32'hFFFF_FFFF, 7'd1);
    send_number(32'hFFFF_FFFF, 7'd2);
    send_number(32'd1, 7'd0);
    send_number(32'd9, 7'd0);
    send_number(32'd10, 7'd0);
    send_number(-32'sd9, 7'd3);
    send_number(-32'sd10, 7'd2);
    send_number(32'd123, 7'd5);
    send_number(-32'sd123, 7'd10);
    send_number(32'd12345, 7'd3);
    send_number(32'd1_000_000_000, 7'd0);
    send_number(-32'sd1_000_000_000, 7'd12);
    send_number(32'd999_999_999, 7'd63);
    send_number(32'd42, 7'd65);
    send_number(-32'sd7, 7'd127);

    // Random numbers: sender light and receiver heavy, then swapped, then free
    for (int n = 0; n < 200; n++) begin
      if (n == 67) begin
        send_gap_pct   = 62;
        recv_stall_pct = 17;
      end else if (n == 134) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      send_number(pick_value(), pick_width());
    end
    s_tvalid <= 1'b0;

    // Drain the remaining text
    while (text_model.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (text_model.errors == 0 && text_model.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
